// ===== hdl/fcpu_pkg.sv =====
`default_nettype none

package fcpu_pkg;

	// Register file shape
	localparam int unsigned NUM_REGS  = 5;
	localparam int unsigned REG_IDX_W = 3;

	// Field widths fixed by the instruction format
	localparam int unsigned CMD_W  = 5;
	localparam int unsigned ADDR_W = 6;
	localparam int unsigned LINE_W = 8;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned BYTE_W = 8;

	// Decoded operations; codes above CMD_HLT act as a no-op
	typedef enum logic [CMD_W-1:0] {
		CMD_MOVRI = 5'd0,
		CMD_MOVRR = 5'd1,
		CMD_STR   = 5'd2,
		CMD_LDR   = 5'd3,
		CMD_STC   = 5'd4,
		CMD_ADDI  = 5'd5,
		CMD_ADDR  = 5'd6,
		CMD_ADDM  = 5'd7,
		CMD_SUBI  = 5'd8,
		CMD_SUBR  = 5'd9,
		CMD_SUBM  = 5'd10,
		CMD_JMP   = 5'd11,
		CMD_JMPZ  = 5'd12,
		CMD_JPN   = 5'd13,
		CMD_JPNLE = 5'd14,
		CMD_PRNR  = 5'd15,
		CMD_PRNM  = 5'd16,
		CMD_HLT   = 5'd17
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_ADDR = 2'd1,
		ERR_JUMP = 2'd2
	} err_t;

	// One result beat
	typedef struct packed {
		logic [LINE_W-1:0] next_line;
		logic              halted;
		err_t              error;
		logic              print_valid;
		logic [WORD_W-1:0] print_value;
	} res_t;

	// State update produced by one instruction
	typedef struct packed {
		logic                 rf_we;
		logic [REG_IDX_W-1:0] rf_idx;
		logic [WORD_W-1:0]    rf_data;
		logic                 dm_we;
		logic [ADDR_W-1:0]    dm_addr;
		logic [BYTE_W-1:0]    dm_data;
	} wb_t;

endpackage

`default_nettype wire

// ===== hdl/fcpu_exec.sv =====
`default_nettype none

module fcpu_exec (
	input  wire logic [fcpu_pkg::CMD_W-1:0]     command,
	input  wire logic [fcpu_pkg::REG_IDX_W-1:0] dest_reg,
	input  wire logic [fcpu_pkg::REG_IDX_W-1:0] src_reg,
	input  wire logic [fcpu_pkg::ADDR_W-1:0]    mem_address,
	input  wire logic [fcpu_pkg::WORD_W-1:0]    immediate,
	input  wire logic [fcpu_pkg::LINE_W-1:0]    jump_line,
	input  wire logic                           addr_ok,
	input  wire logic [fcpu_pkg::WORD_W-1:0]    dest_val,
	input  wire logic [fcpu_pkg::WORD_W-1:0]    src_val,
	input  wire logic [fcpu_pkg::BYTE_W-1:0]    mem_val,
	input  wire logic [fcpu_pkg::LINE_W-1:0]    line,
	input  wire logic [fcpu_pkg::LINE_W-1:0]    program_lines,
	output fcpu_pkg::res_t                      res,
	output fcpu_pkg::wb_t                       wb
);
	import fcpu_pkg::*;

	cmd_t              cmd;
	logic              is_mem;
	logic              jump;
	logic              rf_wr;
	logic [REG_IDX_W-1:0] rf_idx;
	logic [WORD_W-1:0] mem_word;

	assign cmd      = cmd_t'(command);
	assign is_mem   = cmd inside {CMD_STR, CMD_LDR, CMD_STC, CMD_ADDM, CMD_SUBM, CMD_PRNM};
	assign mem_word = {{(WORD_W-BYTE_W){1'b0}}, mem_val};

	// Execute one instruction: result and state update
	always_comb begin
		res             = '0;
		res.error       = ERR_NONE;
		res.next_line   = line + 8'd1;
		wb              = '0;
		wb.dm_addr      = mem_address;
		jump            = 1'b0;
		rf_wr           = 1'b0;
		rf_idx          = dest_reg;

		if (is_mem && !addr_ok) begin
			res.error     = ERR_ADDR;
			res.next_line = line;
		end else begin
			case (cmd)
				CMD_MOVRI: begin
					rf_wr      = 1'b1;
					wb.rf_data = immediate;
				end
				CMD_MOVRR: begin
					rf_wr      = 1'b1;
					rf_idx     = src_reg;
					wb.rf_data = dest_val;
				end
				CMD_STR: begin
					wb.dm_we   = 1'b1;
					wb.dm_data = dest_val[BYTE_W-1:0];
				end
				CMD_LDR: begin
					rf_wr      = 1'b1;
					wb.rf_data = mem_word;
				end
				CMD_STC: begin
					wb.dm_we   = 1'b1;
					wb.dm_data = immediate[BYTE_W-1:0];
				end
				CMD_ADDI: begin
					rf_wr      = 1'b1;
					wb.rf_data = dest_val + immediate;
				end
				CMD_ADDR: begin
					rf_wr      = 1'b1;
					wb.rf_data = dest_val + src_val;
				end
				CMD_ADDM: begin
					rf_wr      = 1'b1;
					wb.rf_data = dest_val + mem_word;
				end
				CMD_SUBI: begin
					rf_wr      = 1'b1;
					wb.rf_data = dest_val - immediate;
				end
				CMD_SUBR: begin
					rf_wr      = 1'b1;
					wb.rf_data = dest_val - src_val;
				end
				CMD_SUBM: begin
					rf_wr      = 1'b1;
					wb.rf_data = dest_val - mem_word;
				end
				CMD_JMP, CMD_JPN: begin
					jump = 1'b1;
				end
				CMD_JMPZ: begin
					jump = (dest_val == '0);
				end
				CMD_JPNLE: begin
					jump = (dest_val == '0) || dest_val[WORD_W-1];
				end
				CMD_PRNR: begin
					res.print_valid = 1'b1;
					res.print_value = dest_val;
				end
				CMD_PRNM: begin
					res.print_valid = 1'b1;
					res.print_value = mem_word;
				end
				CMD_HLT: begin
					res.halted    = 1'b1;
					res.next_line = line;
				end
				default: begin
				end
			endcase

			// Check the target of a taken jump
			if (jump) begin
				if (jump_line == '0 || jump_line > program_lines) begin
					res.error     = ERR_JUMP;
					res.next_line = line;
				end else begin
					res.next_line = jump_line - 8'd1;
				end
			end
		end

		// Drop writes to register numbers beyond the file
		wb.rf_idx = rf_idx;
		wb.rf_we  = rf_wr && ({1'b0, rf_idx} < 4'(NUM_REGS));
	end

endmodule

`default_nettype wire

// ===== hdl/five_register_toy_cpu_execute.sv =====
`default_nettype none

// Executes one decoded instruction per beat against five 32-bit registers,
// a byte data memory of MEM_BYTES entries and an 8-bit line counter, and
// returns one result beat per instruction (next line, halt, error, print).
// An instruction is read out of the register file and data memory in the
// cycle it is taken, then executed, written back and placed in the output
// register when execute advances, which waits while an earlier result is
// held unaccepted; a new command is taken every cycle while results drain.
// Back-to-back dependences are served by forwarding the write-back of the
// previous instruction into the operand registers, so there is no bubble.
// Both memories come out of reset reading as zero with no clearing pass.
// program_lines may only be written while no instruction is in flight.
module five_register_toy_cpu_execute #(
	parameter int unsigned MEM_BYTES = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [fcpu_pkg::LINE_W-1:0]         cfg_wr_data,
	input  wire logic                                cmd_valid,
	output logic                                     cmd_ready,
	input  wire logic [fcpu_pkg::CMD_W-1:0]          command,
	input  wire logic [fcpu_pkg::REG_IDX_W-1:0]      dest_reg,
	input  wire logic [fcpu_pkg::REG_IDX_W-1:0]      src_reg,
	input  wire logic [fcpu_pkg::ADDR_W-1:0]         mem_address,
	input  wire logic signed [fcpu_pkg::WORD_W-1:0]  immediate,
	input  wire logic [fcpu_pkg::LINE_W-1:0]         jump_line,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output logic [fcpu_pkg::LINE_W-1:0]              next_line,
	output logic                                     halted,
	output logic [1:0]                               error,
	output logic                                     print_valid,
	output logic signed [fcpu_pkg::WORD_W-1:0]       print_value
);
	import fcpu_pkg::*;

	localparam int unsigned       AW        = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
	localparam logic [ADDR_W:0]   MEM_LIMIT = (ADDR_W+1)'(MEM_BYTES);

	// Handshake and control
	logic cmd_accept;
	logic s1_adv;
	logic vld_s1;
	logic res_valid_q;

	// Instruction in execute
	logic [CMD_W-1:0]     cmd_s1;
	logic [REG_IDX_W-1:0] rd_s1;
	logic [REG_IDX_W-1:0] rs_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [WORD_W-1:0]    imm_s1;
	logic [LINE_W-1:0]    jl_s1;

	// Architectural state
	logic [LINE_W-1:0] line_q;
	logic [LINE_W-1:0] prog_lines_q;

	// Register file and its read side
	logic [WORD_W-1:0]  rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0] rf_vld_q;
	logic [WORD_W-1:0]  rf_d_s1;
	logic [WORD_W-1:0]  rf_s_s1;
	logic               d_ok_s1;
	logic               s_ok_s1;
	logic               d_fwd_s1;
	logic               s_fwd_s1;
	logic [WORD_W-1:0]  rf_fwd_s1;
	logic               rd_in_range;
	logic               rs_in_range;

	// Data memory and its read side
	logic [BYTE_W-1:0]    dm_mem [MEM_BYTES];
	logic [MEM_BYTES-1:0] dm_vld_q;
	logic [BYTE_W-1:0]    dm_rd_s1;
	logic                 m_ok_s1;
	logic                 m_fwd_s1;
	logic [BYTE_W-1:0]    dm_fwd_s1;
	logic                 addr_in_ok;
	logic                 addr_ok_s1;

	// Operands and execute outputs
	logic [WORD_W-1:0] dest_val;
	logic [WORD_W-1:0] src_val;
	logic [BYTE_W-1:0] mem_val;
	res_t              ex_res;
	wb_t               wb;
	res_t              res_q;

	// Handshake: execute moves on when the output register is free or drains
	assign s1_adv     = vld_s1 && (!res_valid_q || res_ready);
	assign cmd_ready  = !vld_s1 || s1_adv;
	assign cmd_accept = cmd_valid && cmd_ready;

	assign rd_in_range = ({1'b0, dest_reg} < (REG_IDX_W+1)'(NUM_REGS));
	assign rs_in_range = ({1'b0, src_reg} < (REG_IDX_W+1)'(NUM_REGS));
	assign addr_in_ok  = ({1'b0, mem_address} < MEM_LIMIT);
	assign addr_ok_s1  = ({1'b0, addr_s1} < MEM_LIMIT);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			res_valid_q  <= 1'b0;
			line_q       <= '0;
			prog_lines_q <= 8'd255;
			rf_vld_q     <= '0;
			dm_vld_q     <= '0;
		end else begin
			if (cmd_accept) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (s1_adv) begin
				res_valid_q <= 1'b1;
				line_q      <= ex_res.next_line;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				prog_lines_q <= cfg_wr_data;
			end
			if (s1_adv && wb.rf_we) begin
				rf_vld_q[wb.rf_idx] <= 1'b1;
			end
			if (s1_adv && wb.dm_we) begin
				dm_vld_q[wb.dm_addr[AW-1:0]] <= 1'b1;
			end
		end
	end

	// Capture the command and forwarding flags on a beat
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			cmd_s1    <= command;
			rd_s1     <= dest_reg;
			rs_s1     <= src_reg;
			addr_s1   <= mem_address;
			imm_s1    <= immediate;
			jl_s1     <= jump_line;
			d_ok_s1   <= rd_in_range ? rf_vld_q[dest_reg] : 1'b0;
			s_ok_s1   <= rs_in_range ? rf_vld_q[src_reg] : 1'b0;
			m_ok_s1   <= addr_in_ok ? dm_vld_q[mem_address[AW-1:0]] : 1'b0;
			d_fwd_s1  <= s1_adv && wb.rf_we && (wb.rf_idx == dest_reg);
			s_fwd_s1  <= s1_adv && wb.rf_we && (wb.rf_idx == src_reg);
			m_fwd_s1  <= s1_adv && wb.dm_we && (wb.dm_addr == mem_address);
			rf_fwd_s1 <= wb.rf_data;
			dm_fwd_s1 <= wb.dm_data;
		end
	end

	// Register file: two registered reads, one write
	always_ff @(posedge clk) begin
		if (cmd_accept && rd_in_range) begin
			rf_d_s1 <= rf_mem[dest_reg];
		end
		if (cmd_accept && rs_in_range) begin
			rf_s_s1 <= rf_mem[src_reg];
		end
		if (s1_adv && wb.rf_we) begin
			rf_mem[wb.rf_idx] <= wb.rf_data;
		end
	end

	// Data memory: one registered read, one write
	always_ff @(posedge clk) begin
		if (cmd_accept && addr_in_ok) begin
			dm_rd_s1 <= dm_mem[mem_address[AW-1:0]];
		end
		if (s1_adv && wb.dm_we) begin
			dm_mem[wb.dm_addr[AW-1:0]] <= wb.dm_data;
		end
	end

	// Select operands: forwarded write, stored entry, or reset zero
	assign dest_val = d_fwd_s1 ? rf_fwd_s1 : (d_ok_s1 ? rf_d_s1 : '0);
	assign src_val  = s_fwd_s1 ? rf_fwd_s1 : (s_ok_s1 ? rf_s_s1 : '0);
	assign mem_val  = m_fwd_s1 ? dm_fwd_s1 : (m_ok_s1 ? dm_rd_s1 : '0);

	fcpu_exec u_exec (
		.command       (cmd_s1),
		.dest_reg      (rd_s1),
		.src_reg       (rs_s1),
		.mem_address   (addr_s1),
		.immediate     (imm_s1),
		.jump_line     (jl_s1),
		.addr_ok       (addr_ok_s1),
		.dest_val      (dest_val),
		.src_val       (src_val),
		.mem_val       (mem_val),
		.line          (line_q),
		.program_lines (prog_lines_q),
		.res           (ex_res),
		.wb            (wb)
	);

	// Output register: load on advance, hold while stalled
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= ex_res;
		end
	end

	assign res_valid   = res_valid_q;
	assign next_line   = res_q.next_line;
	assign halted      = res_q.halted;
	assign error       = res_q.error;
	assign print_valid = res_q.print_valid;
	assign print_value = res_q.print_value;

`ifndef SYNTH
	// An instruction that reports an error leaves all state untouched
	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && ex_res.error != ERR_NONE) |-> (!wb.rf_we && !wb.dm_we))
		else $error("state write on an erroring instruction");

	// The line counter follows the most recent result beat
	a_line_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (line_q == res_q.next_line))
		else $error("line counter out of step with result");

	// Register writes never target a missing register
	a_rf_idx: assert property (@(posedge clk) disable iff (!arst_n)
		wb.rf_we |-> ({1'b0, wb.rf_idx} < (REG_IDX_W+1)'(NUM_REGS)))
		else $error("register write beyond file");

	// A beat without a print carries a zero value
	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.print_valid) |-> (res_q.print_value == '0))
		else $error("print value set without print");
`endif

endmodule

`default_nettype wire

// ===== verif/fcpu_exec_checker.sv =====
`timescale 1ns / 100ps

module fcpu_exec_checker #(
	parameter int unsigned MEM_BYTES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [fcpu_pkg::LINE_W-1:0]         cfg_wr_data,
	input  logic                                cmd_valid,
	input  logic                                cmd_ready,
	input  logic [fcpu_pkg::CMD_W-1:0]          command,
	input  logic [fcpu_pkg::REG_IDX_W-1:0]      dest_reg,
	input  logic [fcpu_pkg::REG_IDX_W-1:0]      src_reg,
	input  logic [fcpu_pkg::ADDR_W-1:0]         mem_address,
	input  logic [fcpu_pkg::WORD_W-1:0]         immediate,
	input  logic [fcpu_pkg::LINE_W-1:0]         jump_line,
	input  logic                                res_valid,
	input  logic                                res_ready,
	input  logic [fcpu_pkg::LINE_W-1:0]         next_line,
	input  logic                                halted,
	input  logic [1:0]                          error,
	input  logic                                print_valid,
	input  logic [fcpu_pkg::WORD_W-1:0]         print_value,
	output int                                  mismatches,
	output int                                  outstanding
);

	import fcpu_pkg::*;

	// Shadow machine state
	logic [WORD_W-1:0] regs [NUM_REGS];
	logic [BYTE_W-1:0] dmem [MEM_BYTES];
	logic [LINE_W-1:0] line_ctr;
	logic [LINE_W-1:0] prog_lines;

	// Results predicted but not yet seen, oldest first
	res_t pending_results [$];

	function automatic logic [WORD_W-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
		return (idx < NUM_REGS) ? regs[idx] : '0;
	endfunction

	// Writes to a register number beyond the file are dropped
	function automatic void reg_store(input logic [REG_IDX_W-1:0] idx,
			input logic [WORD_W-1:0] val);
		if (idx < NUM_REGS)
			regs[idx] = val;
	endfunction

	// Execute one instruction on the shadow state and return its result beat
	function automatic res_t predict_result(
		input logic [CMD_W-1:0]     op,
		input logic [REG_IDX_W-1:0] rd,
		input logic [REG_IDX_W-1:0] rs,
		input logic [ADDR_W-1:0]    addr,
		input logic [WORD_W-1:0]    imm,
		input logic [LINE_W-1:0]    jl
	);
		res_t        r;
		logic [31:0] d;
		logic        mem_form;
		logic        take;
		r = '0;
		d = reg_value(rd);
		take = 1'b0;
		r.next_line = line_ctr + 8'd1;
		mem_form = op inside {CMD_STR, CMD_LDR, CMD_STC, CMD_ADDM, CMD_SUBM, CMD_PRNM};
		if (mem_form && int'(addr) >= int'(MEM_BYTES)) begin
			r.error = ERR_ADDR;
			r.next_line = line_ctr;
		end else begin
			case (op)
				CMD_MOVRI: reg_store(rd, imm);
				CMD_MOVRR: reg_store(rs, d);
				CMD_STR:   dmem[addr] = d[7:0];
				CMD_LDR:   reg_store(rd, {24'd0, dmem[addr]});
				CMD_STC:   dmem[addr] = imm[7:0];
				CMD_ADDI:  reg_store(rd, d + imm);
				CMD_ADDR:  reg_store(rd, d + reg_value(rs));
				CMD_ADDM:  reg_store(rd, d + {24'd0, dmem[addr]});
				CMD_SUBI:  reg_store(rd, d - imm);
				CMD_SUBR:  reg_store(rd, d - reg_value(rs));
				CMD_SUBM:  reg_store(rd, d - {24'd0, dmem[addr]});
				CMD_JMP:   take = 1'b1;
				CMD_JMPZ:  take = (d == '0);
				CMD_JPN:   take = 1'b1;
				CMD_JPNLE: take = (d == '0) || d[31];
				CMD_PRNR: begin
					r.print_valid = 1'b1;
					r.print_value = d;
				end
				CMD_PRNM: begin
					r.print_valid = 1'b1;
					r.print_value = {24'd0, dmem[addr]};
				end
				CMD_HLT: begin
					r.halted = 1'b1;
					r.next_line = line_ctr;
				end
				default: ;
			endcase
			// Taken jumps are range checked against the program length
			if (take) begin
				if (jl == '0 || jl > prog_lines) begin
					r.error = ERR_JUMP;
					r.next_line = line_ctr;
				end else begin
					r.next_line = jl - 8'd1;
				end
			end
		end
		line_ctr = r.next_line;
		return r;
	endfunction

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got)
			flag($sformatf("%s: expected %0h, got %0h", name, want, got));
	endtask

	// Compare result beats, then advance the shadow state on command beats
	always @(posedge clk or negedge arst_n) begin : monitor
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				regs[i] = '0;
			for (int i = 0; i < MEM_BYTES; i++)
				dmem[i] = '0;
			line_ctr = '0;
			prog_lines = 8'd255;
			pending_results.delete();
		end else begin
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					flag($sformatf("result beat with nothing pending, next_line %0h", next_line));
				end else begin
					want = pending_results.pop_front();
					cmp_field("next_line", want.next_line, next_line);
					cmp_field("halted", want.halted, halted);
					cmp_field("error", want.error, error);
					cmp_field("print_valid", want.print_valid, print_valid);
					cmp_field("print_value", want.print_value, print_value);
				end
			end
			if (cfg_wr_en)
				prog_lines = cfg_wr_data;
			if (cmd_valid && cmd_ready)
				pending_results.push_back(predict_result(command, dest_reg, src_reg,
					mem_address, immediate, jump_line));
		end
		outstanding = pending_results.size();
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

	import fcpu_pkg::*;

	localparam int unsigned MEM_BYTES = 64;
	localparam logic [CMD_W-1:0] OP_UNKNOWN_LO = CMD_HLT + 5'd1;
	localparam logic [CMD_W-1:0] OP_UNKNOWN_HI = 5'd31;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int SQUEEZE_AT = 700;
	localparam int SQUEEZE_CYCLES = 120;

	typedef struct packed {
		logic [CMD_W-1:0]     op;
		logic [REG_IDX_W-1:0] rd;
		logic [REG_IDX_W-1:0] rs;
		logic [ADDR_W-1:0]    addr;
		logic [WORD_W-1:0]    imm;
		logic [LINE_W-1:0]    jl;
	} instr_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [LINE_W-1:0]    cfg_wr_data = '0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	logic [CMD_W-1:0]     command = '0;
	logic [REG_IDX_W-1:0] dest_reg = '0;
	logic [REG_IDX_W-1:0] src_reg = '0;
	logic [ADDR_W-1:0]    mem_address = '0;
	logic [WORD_W-1:0]    immediate = '0;
	logic [LINE_W-1:0]    jump_line = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic [LINE_W-1:0]    next_line;
	logic                 halted;
	logic [1:0]           error;
	logic                 print_valid;
	logic [WORD_W-1:0]    print_value;

	int                   mismatches;
	int                   outstanding;
	int                   offered = 0;
	logic [LINE_W-1:0]    lines = 8'd255;

	five_register_toy_cpu_execute #(
		.MEM_BYTES(MEM_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command(command),
		.dest_reg(dest_reg),
		.src_reg(src_reg),
		.mem_address(mem_address),
		.immediate(immediate),
		.jump_line(jump_line),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.next_line(next_line),
		.halted(halted),
		.error(error),
		.print_valid(print_valid),
		.print_value(print_value)
	);

	fcpu_exec_checker #(
		.MEM_BYTES(MEM_BYTES)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command(command),
		.dest_reg(dest_reg),
		.src_reg(src_reg),
		.mem_address(mem_address),
		.immediate(immediate),
		.jump_line(jump_line),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.next_line(next_line),
		.halted(halted),
		.error(error),
		.print_valid(print_valid),
		.print_value(print_value),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic instr_t mk(input logic [CMD_W-1:0] op, input logic [REG_IDX_W-1:0] rd,
			input logic [REG_IDX_W-1:0] rs, input logic [ADDR_W-1:0] addr,
			input logic [WORD_W-1:0] imm, input logic [LINE_W-1:0] jl);
		instr_t it;
		it.op = op;
		it.rd = rd;
		it.rs = rs;
		it.addr = addr;
		it.imm = imm;
		it.jl = jl;
		return it;
	endfunction

	// Mostly legal opcodes and registers, small values so zero tests hit often
	function automatic instr_t random_instr();
		instr_t it;
		int     pick;
		if ($urandom_range(0, 99) < 85)
			it.op = 5'($urandom_range(0, int'(CMD_HLT)));
		else
			it.op = 5'($urandom_range(int'(OP_UNKNOWN_LO), int'(OP_UNKNOWN_HI)));
		it.rd = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, NUM_REGS - 1)) : 3'($urandom);
		it.rs = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, NUM_REGS - 1)) : 3'($urandom);
		it.addr = 6'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			it.imm = 32'($urandom_range(0, 16)) - 32'd8;
		end else if (pick == 3) begin
			case ($urandom_range(0, 3))
				0: it.imm = 32'h7fff_ffff;
				1: it.imm = 32'h8000_0000;
				2: it.imm = 32'hffff_ffff;
				default: it.imm = '0;
			endcase
		end else begin
			it.imm = $urandom;
		end
		// Jump targets mostly fall inside the program length, with zero and out-of-range outliers
		pick = $urandom_range(0, 9);
		if (pick == 0)
			it.jl = '0;
		else if (pick < 7)
			it.jl = 8'($urandom_range(1, int'(lines)));
		else if (pick == 7)
			it.jl = (lines == 8'd255) ? lines : lines + 8'd1;
		else
			it.jl = 8'($urandom);
		return it;
	endfunction

	// Present one beat and hold it until accepted; returns at a falling edge
	task automatic issue(input instr_t it);
		cmd_valid <= 1'b1;
		command <= it.op;
		dest_reg <= it.rd;
		src_reg <= it.rs;
		mem_address <= it.addr;
		immediate <= it.imm;
		jump_line <= it.jl;
		offered++;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			cmd_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Drop valid and wait until every result is back before touching config
	task automatic drain();
		cmd_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_lines(input logic [LINE_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		lines = v;
	endtask

	// Receiver: random stall modes, plus one long hold-off mid-run
	initial begin : result_sink
		int mode;
		int span;
		int hold;
		bit squeezed;
		hold = 0;
		squeezed = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 60);
			for (int i = 0; i < span; i++) begin
				@(negedge clk);
				if (!squeezed && offered >= SQUEEZE_AT) begin
					squeezed = 1'b1;
					hold = SQUEEZE_CYCLES;
				end
				if (hold > 0) begin
					hold--;
					res_ready <= 1'b0;
				end else begin
					case (mode)
						0, 1: res_ready <= 1'b1;
						2: res_ready <= 1'($urandom_range(0, 1));
						default: res_ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	initial begin : stimulus
		int left;
		int burst;
		logic [LINE_W-1:0] phase_lines;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: arithmetic wrap, every operation, ghost registers, jump cases
		issue(mk(CMD_MOVRI, 3'd0, 3'd0, 6'd0, 32'h7fff_ffff, 8'd0));
		issue(mk(CMD_ADDI, 3'd0, 3'd0, 6'd0, 32'd1, 8'd0));
		issue(mk(CMD_MOVRI, 3'd1, 3'd0, 6'd0, 32'hffff_ffff, 8'd0));
		issue(mk(CMD_SUBI, 3'd1, 3'd0, 6'd0, 32'hffff_ffff, 8'd0));
		issue(mk(CMD_MOVRR, 3'd0, 3'd2, 6'd0, 32'd0, 8'd0));
		issue(mk(CMD_ADDR, 3'd2, 3'd0, 6'd0, 32'd0, 8'd0));
		issue(mk(CMD_SUBR, 3'd3, 3'd0, 6'd0, 32'd0, 8'd0));
		issue(mk(CMD_MOVRI, 3'd4, 3'd0, 6'd0, 32'h1234_5678, 8'd0));
		issue(mk(CMD_STR, 3'd4, 3'd0, 6'd63, 32'd0, 8'd0));
		issue(mk(CMD_STC, 3'd0, 3'd0, 6'd0, 32'hffff_ffa5, 8'd0));
		issue(mk(CMD_LDR, 3'd1, 3'd0, 6'd0, 32'd0, 8'd0));
		issue(mk(CMD_ADDM, 3'd2, 3'd0, 6'd63, 32'd0, 8'd0));
		issue(mk(CMD_SUBM, 3'd3, 3'd0, 6'd0, 32'd0, 8'd0));
		issue(mk(CMD_PRNR, 3'd1, 3'd0, 6'd0, 32'd0, 8'd0));
		issue(mk(CMD_PRNM, 3'd0, 3'd0, 6'd63, 32'd0, 8'd0));
		issue(mk(CMD_PRNR, 3'd7, 3'd0, 6'd0, 32'd0, 8'd0));
		issue(mk(CMD_MOVRI, 3'd5, 3'd0, 6'd0, 32'd123, 8'd0));
		issue(mk(CMD_JMPZ, 3'd6, 3'd0, 6'd0, 32'd0, 8'd255));
		issue(mk(CMD_JMPZ, 3'd1, 3'd0, 6'd0, 32'd0, 8'd0));
		issue(mk(CMD_JPNLE, 3'd0, 3'd0, 6'd0, 32'd0, 8'd1));
		issue(mk(CMD_JPNLE, 3'd2, 3'd0, 6'd0, 32'd0, 8'd0));
		issue(mk(CMD_JMP, 3'd0, 3'd0, 6'd0, 32'd0, 8'd0));
		issue(mk(CMD_JPN, 3'd0, 3'd0, 6'd0, 32'd0, 8'd128));
		issue(mk(CMD_HLT, 3'd0, 3'd0, 6'd0, 32'd0, 8'd0));
		issue(mk(OP_UNKNOWN_HI, 3'd0, 3'd0, 6'd0, 32'd0, 8'd0));
		issue(mk(OP_UNKNOWN_LO, 3'd0, 3'd0, 6'd0, 32'd0, 8'd0));
		drain();

		// Random phases, each under its own program length
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: phase_lines = 8'd1;
				1: phase_lines = 8'd255;
				3: phase_lines = 8'd2;
				5: phase_lines = 8'd254;
				default: phase_lines = 8'($urandom_range(3, 253));
			endcase
			write_lines(phase_lines);
			left = ITEMS_PER_PHASE;
			while (left > 0) begin
				burst = $urandom_range(1, 24);
				for (int k = 0; k < burst && left > 0; k++) begin
					issue(random_instr());
					left--;
				end
				if ($urandom_range(0, 9) < 3)
					pause(0);
				else
					pause($urandom_range(1, 6));
			end
			drain();
		end

		repeat (10) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/fcpu_pkg.sv
hdl/fcpu_exec.sv
hdl/five_register_toy_cpu_execute.sv
verif/fcpu_exec_checker.sv
verif/tb.sv
